@@ hdl/ext2fp_pkg.sv @@
// shared types and constants for the extended to double/single store conversion
`default_nettype none

package ext2fp_pkg;

    // rounding control register encoding
    typedef enum logic [1:0] {
        RC_NEAREST = 2'd0,
        RC_DOWN    = 2'd1,
        RC_UP      = 2'd2,
        RC_ZERO    = 2'd3
    } rc_t;

    // rounding as it acts on the magnitude for the sign at hand
    typedef enum logic [1:0] {
        AP_NEAR  = 2'd0,
        AP_TRUNC = 2'd1,
        AP_HARD  = 2'd2
    } applied_t;

    typedef struct packed {
        logic [63:0] significand_in;
        logic [15:0] sign_exponent_in;
        logic        target_is_double;
    } req_t;

    typedef struct packed {
        logic [63:0] result_bits;
        logic        invalid_flag;
        logic        overflow_flag;
        logic        underflow_flag;
        logic        precision_flag;
        logic        round_up_flag;
    } rsp_t;

    localparam logic [14:0] EXT_EXP_MAX = 15'h7fff;

    // extended bias minus target bias
    localparam logic [16:0] DBL_BIAS_ADJ = 17'd15360;
    localparam logic [16:0] SGL_BIAS_ADJ = 17'd16256;

    // target exponent limits
    localparam logic signed [16:0] DBL_EXP_MAX  = 17'sd2047;
    localparam logic signed [16:0] SGL_EXP_MAX  = 17'sd255;
    localparam logic signed [16:0] DBL_DEEP_LIM = -17'sd52;
    localparam logic signed [16:0] SGL_DEEP_LIM = -17'sd23;

    // denormal shift is (dropped bits + 1) minus target exponent
    localparam logic [16:0] DBL_DEN_BASE = 17'd12;
    localparam logic [16:0] SGL_DEN_BASE = 17'd41;

    // rounding increments at the dropped fraction width
    localparam logic [63:0] DBL_HALF_M1 = 64'h0000_0000_0000_03ff;
    localparam logic [63:0] SGL_HALF_M1 = 64'h0000_007f_ffff_ffff;
    localparam logic [63:0] DBL_ULP_M1  = 64'h0000_0000_0000_07ff;
    localparam logic [63:0] SGL_ULP_M1  = 64'h0000_00ff_ffff_ffff;

    localparam logic [63:0] DBL_EXP_MASK = 64'h7ff0_0000_0000_0000;
    localparam logic [63:0] SGL_EXP_MASK = 64'h0000_0000_7f80_0000;

endpackage

`default_nettype wire

@@ hdl/ext2fp_if.sv @@
// valid/ready channel interfaces for conversion requests and results
`default_nettype none

interface ext2fp_req_if;
    logic        valid;
    logic        ready;
    logic [63:0] significand_in;
    logic [15:0] sign_exponent_in;
    logic        target_is_double;

    modport source (
        output valid,
        output significand_in,
        output sign_exponent_in,
        output target_is_double,
        input  ready
    );

    modport sink (
        input  valid,
        input  significand_in,
        input  sign_exponent_in,
        input  target_is_double,
        output ready
    );
endinterface

interface ext2fp_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_bits;
    logic        invalid_flag;
    logic        overflow_flag;
    logic        underflow_flag;
    logic        precision_flag;
    logic        round_up_flag;

    modport source (
        output valid,
        output result_bits,
        output invalid_flag,
        output overflow_flag,
        output underflow_flag,
        output precision_flag,
        output round_up_flag,
        input  ready
    );

    modport sink (
        input  valid,
        input  result_bits,
        input  invalid_flag,
        input  overflow_flag,
        input  underflow_flag,
        input  precision_flag,
        input  round_up_flag,
        output ready
    );
endinterface

`default_nettype wire

@@ hdl/ext2fp_convert.sv @@
// combinational rounding, range check and encoding of one extended value
`default_nettype none

module ext2fp_convert (
    input  var ext2fp_pkg::req_t item,
    input  var ext2fp_pkg::rc_t  rounding_mode,
    output var ext2fp_pkg::rsp_t result
);

    logic                  dbl;
    logic                  sbit;
    logic [14:0]           exp_in;
    logic [62:0]           frac;
    logic                  frac_nz;
    logic [63:0]           sign_vec;
    logic [63:0]           exp_mask;
    ext2fp_pkg::applied_t  applied;
    logic                  lsb_in;
    logic [63:0]           add_val;
    logic [63:0]           sum;
    logic [62:0]           rfrac;
    logic                  carry;
    logic [16:0]           te_raw;
    logic signed [16:0]    te;
    logic                  te_nonpos;
    logic                  te_deep;
    logic                  te_ovf;
    logic [16:0]           shamt_full;
    logic [5:0]            shamt;
    logic [63:0]           den_bits;
    logic                  dropped_nz;
    logic                  rounded_lsb;
    logic                  is_hard;
    logic                  is_trunc;

    always_comb
    begin
        dbl     = item.target_is_double;
        sbit    = item.sign_exponent_in[15];
        exp_in  = item.sign_exponent_in[14:0];
        frac    = item.significand_in[62:0];
        frac_nz = (frac != 63'd0);

        sign_vec = dbl ? {sbit, 63'd0} : {32'd0, sbit, 31'd0};
        exp_mask = dbl ? ext2fp_pkg::DBL_EXP_MASK : ext2fp_pkg::SGL_EXP_MASK;

        unique case (rounding_mode)
            ext2fp_pkg::RC_NEAREST: applied = ext2fp_pkg::AP_NEAR;
            ext2fp_pkg::RC_ZERO:    applied = ext2fp_pkg::AP_TRUNC;
            ext2fp_pkg::RC_DOWN:    applied = sbit ? ext2fp_pkg::AP_HARD : ext2fp_pkg::AP_TRUNC;
            ext2fp_pkg::RC_UP:      applied = sbit ? ext2fp_pkg::AP_TRUNC : ext2fp_pkg::AP_HARD;
            default:                applied = ext2fp_pkg::AP_NEAR;
        endcase
        is_hard  = (applied == ext2fp_pkg::AP_HARD);
        is_trunc = (applied == ext2fp_pkg::AP_TRUNC);

        // nearest even adds half minus one, plus the kept lsb
        lsb_in = dbl ? frac[11] : frac[40];
        case (applied)
            ext2fp_pkg::AP_NEAR:
                add_val = (dbl ? ext2fp_pkg::DBL_HALF_M1 : ext2fp_pkg::SGL_HALF_M1)
                          + {63'd0, lsb_in};
            ext2fp_pkg::AP_HARD:
                add_val = dbl ? ext2fp_pkg::DBL_ULP_M1 : ext2fp_pkg::SGL_ULP_M1;
            default:
                add_val = 64'd0;
        endcase

        sum   = {1'b0, frac} + add_val;
        carry = sum[63];
        rfrac = sum[62:0];

        te_raw = {2'b00, exp_in} + {16'd0, carry}
                 - (dbl ? ext2fp_pkg::DBL_BIAS_ADJ : ext2fp_pkg::SGL_BIAS_ADJ);
        te     = $signed(te_raw);

        te_nonpos = (te <= 17'sd0);
        te_deep   = dbl ? (te <= ext2fp_pkg::DBL_DEEP_LIM) : (te <= ext2fp_pkg::SGL_DEEP_LIM);
        te_ovf    = dbl ? (te >= ext2fp_pkg::DBL_EXP_MAX) : (te >= ext2fp_pkg::SGL_EXP_MAX);

        // shift stays within 12..63 (double) or 41..63 (single) in the denormal range
        shamt_full = (dbl ? ext2fp_pkg::DBL_DEN_BASE : ext2fp_pkg::SGL_DEN_BASE) - te_raw;
        shamt      = shamt_full[5:0];
        den_bits   = {1'b1, rfrac} >> shamt;

        dropped_nz  = dbl ? (frac[10:0] != 11'd0) : (frac[39:0] != 40'd0);
        rounded_lsb = dbl ? rfrac[11] : rfrac[40];

        result = '0;
        if (exp_in == ext2fp_pkg::EXT_EXP_MAX)
        begin
            // infinity or nan, quiet bit forced on nonzero fraction
            result.invalid_flag = frac_nz && !frac[62];
            if (dbl)
                result.result_bits = {sbit, 11'h7ff, frac[62] | frac_nz, frac[61:11]};
            else
                result.result_bits = {32'd0, sbit, 8'hff, frac[62] | frac_nz, frac[61:40]};
        end
        else if (exp_in == 15'd0 && !frac_nz)
        begin
            result.result_bits = sign_vec;
        end
        else if (te_nonpos)
        begin
            result.precision_flag = 1'b1;
            if (te_deep)
            begin
                result.underflow_flag = 1'b1;
                result.round_up_flag  = is_hard;
                result.result_bits    = sign_vec | {63'd0, is_hard};
            end
            else
            begin
                // leading one always survives the shift, never zero here
                result.result_bits = sign_vec | den_bits;
            end
        end
        else if (te_ovf)
        begin
            result.result_bits    = (sign_vec | exp_mask) - {63'd0, is_trunc};
            result.overflow_flag  = 1'b1;
            result.precision_flag = 1'b1;
            result.round_up_flag  = !is_trunc;
        end
        else
        begin
            result.precision_flag = dropped_nz;
            result.round_up_flag  = dropped_nz && (lsb_in ^ rounded_lsb);
            if (dbl)
                result.result_bits = {sbit, te_raw[10:0], rfrac[62:11]};
            else
                result.result_bits = {32'd0, sbit, te_raw[7:0], rfrac[62:40]};
        end
    end

endmodule

`default_nettype wire

@@ hdl/extended_to_fp32_fp64_store.sv @@
// top level: extended precision to double or single store conversion
// Converts one 80-bit extended value per item into a double, or a single in the low 32 bits,
// with invalid, overflow, underflow, precision and round-up flags. The rounding mode comes from
// a two-bit register (nearest even, down, up, toward zero), written through cfg_write_enable /
// cfg_write_data while no item is in flight; the user must ensure this, the block does not.
// One item is accepted every cycle while results are taken as presented: the item lands in
// an input register, the rounding add, range check and encoding run in one pass of logic,
// and the result waits in an output register until taken. No clearing pass after reset.
`default_nettype none

module extended_to_fp32_fp64_store (
    input  wire logic         clk,
    input  wire logic         rst_n,
    ext2fp_req_if.sink        req,
    ext2fp_rsp_if.source      rsp,
    input  wire logic         cfg_write_enable,
    input  wire logic [1:0]   cfg_write_data
);

    ext2fp_pkg::rc_t  rounding_control_reg;
    logic             in_valid_reg;
    logic             in_valid_next;
    ext2fp_pkg::req_t in_item_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    ext2fp_pkg::rsp_t out_item_reg;
    ext2fp_pkg::rsp_t out_item_next;
    logic             out_free;
    logic             advance;
    logic             take_in;

    ext2fp_convert u_convert (
        .item          (in_item_reg),
        .rounding_mode (rounding_control_reg),
        .result        (out_item_next)
    );

    assign out_free  = !out_valid_reg || rsp.ready;
    assign advance   = in_valid_reg && out_free;
    assign req.ready = !in_valid_reg || out_free;
    assign take_in   = req.valid && req.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take_in)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rounding_control_reg <= ext2fp_pkg::RC_NEAREST;
            in_valid_reg         <= 1'b0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_write_enable)
                rounding_control_reg <= ext2fp_pkg::rc_t'(cfg_write_data);
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_item_reg.significand_in   <= req.significand_in;
            in_item_reg.sign_exponent_in <= req.sign_exponent_in;
            in_item_reg.target_is_double <= req.target_is_double;
        end
        if (advance)
            out_item_reg <= out_item_next;
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.result_bits    = out_item_reg.result_bits;
    assign rsp.invalid_flag   = out_item_reg.invalid_flag;
    assign rsp.overflow_flag  = out_item_reg.overflow_flag;
    assign rsp.underflow_flag = out_item_reg.underflow_flag;
    assign rsp.precision_flag = out_item_reg.precision_flag;
    assign rsp.round_up_flag  = out_item_reg.round_up_flag;

endmodule

`default_nettype wire
